// ===== hdl/hslc_pkg.sv =====
package hslc_pkg;

    // configuration channel
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OPACITY     = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK_ENABLE = CFG_INDEX_BITS'(1);

endpackage

// ===== hdl/hslc_if.sv =====
interface hslc_pix_in_if #(parameter int W = 16) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] base_red;
    logic [W-1:0] base_green;
    logic [W-1:0] base_blue;
    logic [W-1:0] base_alpha;
    logic [W-1:0] layer_red;
    logic [W-1:0] layer_green;
    logic [W-1:0] layer_blue;
    logic [W-1:0] layer_alpha;
    logic [W-1:0] mask_value;
    logic         last_pixel;

    modport source (
        output valid, base_red, base_green, base_blue, base_alpha,
        output layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, base_red, base_green, base_blue, base_alpha,
        input  layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_pixel,
        output ready
    );
endinterface

interface hslc_pix_out_if #(parameter int W = 16) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] out_red;
    logic [W-1:0] out_green;
    logic [W-1:0] out_blue;
    logic [W-1:0] out_alpha;
    logic         out_last;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_last,
        output ready
    );
endinterface

interface hslc_cfg_if import hslc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ===== hdl/hsl_color_blend_composite.sv =====
// Channel   Modport  Beat contents
// --------  -------  ------------------------------------------------------
// cfg       sink     reg_index, reg_data (opacity, mask_enable)
// pix_in    sink     base rgba, layer rgba, mask_value, last_pixel
// pix_out   source   out rgb, out_alpha, out_last
//
// One pixel per cycle while pix_out takes beats. Latency is set by the ratio path:
// three alpha multiplies, then a one-bit-per-stage divider (CHANNEL_BITS + 3 stages).
// The whole pipeline advances together; it stalls only while the last stage holds
// a beat that pix_out has not taken. Reset clears the valid bits and the config
// registers; the data registers are not reset.
module hsl_color_blend_composite import hslc_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    hslc_cfg_if.sink         cfg,
    hslc_pix_in_if.sink      pix_in,
    hslc_pix_out_if.source   pix_out
);
    localparam int W  = CHANNEL_BITS;
    localparam int Q  = W + 2;
    localparam int HW = W + 4;
    localparam int SD = Q + 3;   // saturation / hue quotients ready
    localparam int SR = Q + 7;   // ratio quotient ready
    localparam int D  = Q + 11;  // output stage

    localparam logic [W-1:0]   ONE    = '1;
    localparam logic [2*W-1:0] HALF   = (2*W)'(ONE >> 1);
    localparam logic [HW-1:0]  ONE_H  = HW'(ONE);
    localparam logic [HW-1:0]  TWO_H  = ONE_H << 1;
    localparam logic [HW-1:0]  THREE_H = (ONE_H << 1) + ONE_H;
    localparam logic [HW-1:0]  FOUR_H = ONE_H << 2;
    localparam logic [HW-1:0]  SIX_H  = (ONE_H << 2) + (ONE_H << 1);

    typedef enum logic [1:0] {HUE_RED, HUE_GREEN, HUE_BLUE} hue_sel_t;
    typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

    // x / (2^W - 1) for x below 2^(2W)
    function automatic logic [W-1:0] fx_fix(input logic [2*W-1:0] x);
        logic [2*W:0] t;
        t = {1'b0, x} + (2*W+1)'(x >> W) + (2*W+1)'(1);
        return t[2*W-1:W];
    endfunction

    function automatic logic [HW-1:0] wrap6(input logic [HW-1:0] x);
        return (x >= SIX_H) ? x - SIX_H : x;
    endfunction

    function automatic seg_t seg_mode(input logic [HW-1:0] t);
        if (t < ONE_H)
            return SEG_RISE;
        else if (t < THREE_H)
            return SEG_HIGH;
        else if (t < FOUR_H)
            return SEG_FALL;
        else
            return SEG_LOW;
    endfunction

    function automatic logic [W-1:0] seg_frac(input logic [HW-1:0] t);
        if (t < ONE_H)
            return t[W-1:0];
        else
            return W'(FOUR_H - t);
    endfunction

    // ---------------- configuration
    logic [W-1:0] opac_reg;
    logic         mask_en_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opac_reg    <= '1;
            mask_en_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                REG_OPACITY:     opac_reg    <= W'(cfg.reg_data);
                REG_MASK_ENABLE: mask_en_reg <= cfg.reg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control
    logic [D:1] v_reg;
    logic       en;

    assign en           = !v_reg[D] || pix_out.ready;
    assign pix_in.ready = en;
    assign pix_out.valid = v_reg[D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[D-1:1], pix_in.valid};
    end

    // ---------------- input stage logic
    logic [W-1:0] in_b [3];
    logic [W-1:0] bmx, bmn, lmx, lmn, min_a;
    logic [W:0]   bsum;
    hue_sel_t     hsel_in;
    logic [W-1:0] hp_in, hn_in;

    assign in_b[0] = pix_in.base_red;
    assign in_b[1] = pix_in.base_green;
    assign in_b[2] = pix_in.base_blue;

    always_comb
    begin
        bmx = (in_b[0] > in_b[1]) ? in_b[0] : in_b[1];
        bmx = (bmx > in_b[2]) ? bmx : in_b[2];
        bmn = (in_b[0] < in_b[1]) ? in_b[0] : in_b[1];
        bmn = (bmn < in_b[2]) ? bmn : in_b[2];
        bsum = {1'b0, bmx} + {1'b0, bmn} + (W+1)'(1);

        lmx = (pix_in.layer_red > pix_in.layer_green) ? pix_in.layer_red : pix_in.layer_green;
        lmx = (lmx > pix_in.layer_blue) ? lmx : pix_in.layer_blue;
        lmn = (pix_in.layer_red < pix_in.layer_green) ? pix_in.layer_red : pix_in.layer_green;
        lmn = (lmn < pix_in.layer_blue) ? lmn : pix_in.layer_blue;

        if (pix_in.layer_red == lmx)
        begin
            hsel_in = HUE_RED;
            hp_in   = pix_in.layer_green;
            hn_in   = pix_in.layer_blue;
        end
        else if (pix_in.layer_green == lmx)
        begin
            hsel_in = HUE_GREEN;
            hp_in   = pix_in.layer_blue;
            hn_in   = pix_in.layer_red;
        end
        else
        begin
            hsel_in = HUE_BLUE;
            hp_in   = pix_in.layer_red;
            hn_in   = pix_in.layer_green;
        end

        min_a = (pix_in.base_alpha < pix_in.layer_alpha) ? pix_in.base_alpha
                                                         : pix_in.layer_alpha;
    end

    // ---------------- pipeline registers
    logic [W-1:0]   brgb_d  [1:D][3];
    logic [W-1:0]   ba_d    [1:D];
    logic           last_d  [1:D];
    logic [W-1:0]   l_d     [1:Q+6];
    logic           zero_d  [6:D-1];
    hue_sel_t       hsel1_reg;
    hue_sel_t       hsel_d  [2:SD];
    logic           nneg_d  [2:SD];
    logic           dz_d    [2:SD];

    logic [2*W-1:0] p1_reg, p3_reg, p5_reg;
    logic [W-1:0]   mv1_reg, mv2_reg, comp0_2_reg, comp0_3_reg, comp4_reg, comp5_reg;
    logic [W-1:0]   comp6_reg, newa6_reg;
    logic [W-1:0]   mx1_reg, mn1_reg, hp1_reg, hn1_reg;
    logic [W-1:0]   delta2_reg, denom2_reg, nabs2_reg;

    logic [W-1:0]   s4_reg, s5_reg;
    logic [HW-1:0]  h6_4_reg;
    logic [2*W-1:0] pls5_reg;
    logic [HW-1:0]  t5_reg [3];
    seg_t           mode6_reg [3], mode7_reg [3], mode8_reg [3];
    logic [W-1:0]   frac6_reg [3], frac7_reg [3];
    logic [W-1:0]   m2_6_reg, m2_7_reg, m2_8_reg, m1_7_reg, m1_8_reg;
    logic [2*W-1:0] prod8_reg [3];
    logic [W-1:0]   c9_reg [3];
    logic [W-1:0]   ratio8_reg, ratio9_reg;
    logic [2*W-1:0] pc10_reg [3], pb10_reg [3];
    logic [W-1:0]   out_rgb_reg [3];

    logic [Q-1:0]   qs, qh, qr;

    // ---------------- dividers
    hslc_div #(.W(W)) u_div_sat (
        .clk (clk), .en (en), .num (delta2_reg), .den (denom2_reg), .quo (qs)
    );
    hslc_div #(.W(W)) u_div_hue (
        .clk (clk), .en (en), .num (nabs2_reg), .den (delta2_reg), .quo (qh)
    );
    hslc_div #(.W(W)) u_div_ratio (
        .clk (clk), .en (en), .num (comp6_reg), .den (newa6_reg), .quo (qr)
    );

    // ---------------- combinational pieces between stages
    logic [W-1:0]  comp4_next, newa_next;
    logic [W:0]    newa_sum, lsum, twol6, twol7, m2_sum;
    logic [W-1:0]  denom_next, ml6, l5, l6, m1_next, m2_next;
    logic [HW-1:0] hue_base, hue_raw, qh_h;

    always_comb
    begin
        comp4_next = mask_en_reg ? fx_fix(p3_reg) : comp0_3_reg;

        newa_sum  = {1'b0, ba_d[5]} + {1'b0, fx_fix(p5_reg)};
        newa_next = (newa_sum > {1'b0, ONE}) ? ONE : newa_sum[W-1:0];

        lsum = {1'b0, mx1_reg} + {1'b0, mn1_reg};
        denom_next = (lsum <= {1'b0, ONE}) ? lsum[W-1:0] : W'({ONE, 1'b0} - lsum);

        case (hsel_d[SD])
            HUE_RED:   hue_base = '0;
            HUE_GREEN: hue_base = TWO_H;
            HUE_BLUE:  hue_base = FOUR_H;
            default:   hue_base = '0;
        endcase
        qh_h    = HW'(qh);
        hue_raw = nneg_d[SD] ? hue_base + SIX_H - qh_h : hue_base + qh_h;

        // m2 from base lightness and layer saturation
        ml6   = fx_fix(pls5_reg);
        l5    = l_d[Q+5];
        twol6 = {l5, 1'b0};
        if (twol6 <= {1'b0, ONE})
            m2_sum = {1'b0, l5} + {1'b0, ml6};
        else
            m2_sum = {1'b0, l5} + {1'b0, s5_reg} - {1'b0, ml6};
        m2_next = (m2_sum > {1'b0, ONE}) ? ONE : m2_sum[W-1:0];

        l6      = l_d[Q+6];
        twol7   = {l6, 1'b0};
        m1_next = (twol7 > {1'b0, m2_6_reg}) ? W'(twol7 - {1'b0, m2_6_reg}) : '0;
        if (m1_next > m2_6_reg)
            m1_next = m2_6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // passthrough lines
            brgb_d[1] <= in_b;
            ba_d[1]   <= pix_in.base_alpha;
            last_d[1] <= pix_in.last_pixel;
            for (int k = 2; k <= D; k++)
            begin
                brgb_d[k] <= brgb_d[k-1];
                ba_d[k]   <= ba_d[k-1];
                last_d[k] <= last_d[k-1];
            end
            l_d[1] <= bsum[W:1];
            for (int k = 2; k <= Q+6; k++)
                l_d[k] <= l_d[k-1];

            // alpha path
            p1_reg      <= (2*W)'(min_a) * (2*W)'(opac_reg) + HALF;
            mv1_reg     <= pix_in.mask_value;
            comp0_2_reg <= fx_fix(p1_reg);
            mv2_reg     <= mv1_reg;
            p3_reg      <= (2*W)'(comp0_2_reg) * (2*W)'(mv2_reg) + HALF;
            comp0_3_reg <= comp0_2_reg;
            comp4_reg   <= comp4_next;
            p5_reg      <= (2*W)'(ONE - ba_d[4]) * (2*W)'(comp4_reg) + HALF;
            comp5_reg   <= comp4_reg;
            comp6_reg   <= comp5_reg;
            newa6_reg   <= newa_next;
            zero_d[6]   <= (comp5_reg == '0) || (newa_next == '0);
            for (int k = 7; k <= D-1; k++)
                zero_d[k] <= zero_d[k-1];

            // layer hue / saturation setup
            mx1_reg    <= lmx;
            mn1_reg    <= lmn;
            hp1_reg    <= hp_in;
            hn1_reg    <= hn_in;
            hsel1_reg  <= hsel_in;
            hsel_d[2]  <= hsel1_reg;
            delta2_reg <= mx1_reg - mn1_reg;
            denom2_reg <= denom_next;
            nabs2_reg  <= (hp1_reg >= hn1_reg) ? hp1_reg - hn1_reg : hn1_reg - hp1_reg;
            nneg_d[2]  <= hp1_reg < hn1_reg;
            dz_d[2]    <= mx1_reg == mn1_reg;
            for (int k = 3; k <= SD; k++)
            begin
                hsel_d[k] <= hsel_d[k-1];
                nneg_d[k] <= nneg_d[k-1];
                dz_d[k]   <= dz_d[k-1];
            end

            // saturation, hue
            s4_reg   <= dz_d[SD] ? '0 : ((qs > Q'(ONE)) ? ONE : qs[W-1:0]);
            h6_4_reg <= dz_d[SD] ? '0 : wrap6(hue_raw);

            // lightness product and sector positions
            pls5_reg  <= (2*W)'(l_d[Q+4]) * (2*W)'(s4_reg) + HALF;
            s5_reg    <= s4_reg;
            t5_reg[0] <= wrap6(h6_4_reg + TWO_H);
            t5_reg[1] <= h6_4_reg;
            t5_reg[2] <= wrap6(h6_4_reg + FOUR_H);

            m2_6_reg <= m2_next;
            m1_7_reg <= m1_next;
            m2_7_reg <= m2_6_reg;
            m1_8_reg <= m1_7_reg;
            m2_8_reg <= m2_7_reg;

            ratio8_reg <= (qr > Q'(ONE)) ? ONE : qr[W-1:0];
            ratio9_reg <= ratio8_reg;

            for (int c = 0; c < 3; c++)
            begin
                mode6_reg[c] <= seg_mode(t5_reg[c]);
                frac6_reg[c] <= seg_frac(t5_reg[c]);
                mode7_reg[c] <= mode6_reg[c];
                frac7_reg[c] <= frac6_reg[c];
                mode8_reg[c] <= mode7_reg[c];
                prod8_reg[c] <= (2*W)'(m2_7_reg - m1_7_reg) * (2*W)'(frac7_reg[c]) + HALF;

                case (mode8_reg[c])
                    SEG_RISE, SEG_FALL: c9_reg[c] <= m1_8_reg + fx_fix(prod8_reg[c]);
                    SEG_HIGH:           c9_reg[c] <= m2_8_reg;
                    SEG_LOW:            c9_reg[c] <= m1_8_reg;
                    default:            c9_reg[c] <= m1_8_reg;
                endcase

                pc10_reg[c] <= (2*W)'(c9_reg[c]) * (2*W)'(ratio9_reg);
                pb10_reg[c] <= (2*W)'(brgb_d[Q+9][c]) * (2*W)'(ONE - ratio9_reg);

                out_rgb_reg[c] <= zero_d[D-1] ? brgb_d[D-1][c]
                                              : fx_fix(pc10_reg[c] + pb10_reg[c] + HALF);
            end
        end
    end

    assign pix_out.out_red   = out_rgb_reg[0];
    assign pix_out.out_green = out_rgb_reg[1];
    assign pix_out.out_blue  = out_rgb_reg[2];
    assign pix_out.out_alpha = ba_d[D];
    assign pix_out.out_last  = last_d[D];

endmodule

// ===== hdl/hslc_div.sv =====
// Pipelined restoring divider: quo = (num * (2^W - 1) + den / 2) / den.
// One quotient bit per stage; the quotient is registered. Quotient must fit W + 2 bits.
module hslc_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W+1:0] quo
);
    localparam int Q = W + 2;

    logic [W-1:0]   rem_reg [0:Q];
    logic [Q-1:0]   lo_reg  [0:Q];
    logic [W-1:0]   den_reg [0:Q];
    logic [Q-1:0]   quo_reg [0:Q];
    logic [2*W-1:0] dvd;

    assign dvd = ({num, W'(0)} - (2*W)'(num)) + (2*W)'(den >> 1);

    always_ff @(posedge clk)
    begin
        logic [W:0] trial;
        logic       ge;
        if (en)
        begin
            rem_reg[0] <= W'(dvd >> Q);
            lo_reg[0]  <= dvd[Q-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            for (int i = 1; i <= Q; i++)
            begin
                trial = {rem_reg[i-1], lo_reg[i-1][Q-1]};
                ge    = trial >= {1'b0, den_reg[i-1]};
                rem_reg[i] <= ge ? W'(trial - {1'b0, den_reg[i-1]}) : W'(trial);
                lo_reg[i]  <= {lo_reg[i-1][Q-2:0], 1'b0};
                den_reg[i] <= den_reg[i-1];
                quo_reg[i] <= {quo_reg[i-1][Q-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[Q];

endmodule

// ===== bench/hsl_color_blend_composite_test.sv =====
`timescale 1ns / 1ps

module hsl_color_blend_composite_test;
    import hslc_pkg::*;

    localparam int W = 16;
    localparam logic [63:0] ONE = 64'd65535;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(7);
    localparam int LATENCY = W + 13;

    typedef struct packed {
        logic [W-1:0] br, bg, bb, ba;
        logic [W-1:0] lr, lg, lb, la;
        logic [W-1:0] mv;
        logic         last;
    } pixel_t;

    typedef struct packed {
        logic [W-1:0] r, g, b, a;
        logic         last;
    } blended_t;

    typedef struct packed {
        pixel_t   px;
        logic     typed;
        blended_t res;
    } row_t;

    logic clk;
    logic rst_n;

    hslc_cfg_if        cfg ();
    hslc_pix_in_if  #(W) pix_in ();
    hslc_pix_out_if #(W) pix_out ();

    hsl_color_blend_composite #(.CHANNEL_BITS(W)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    logic [W-1:0] opacity_q;
    logic         mask_en_q;
    blended_t     pending_px[$];
    int           err_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_asked;
    int           hold_taken;
    int           hold_left;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
        return (a * b + ONE / 2) / ONE;
    endfunction

    function automatic logic [63:0] fdiv(logic [63:0] n, logic [63:0] d);
        return (n * ONE + d / 2) / d;
    endfunction

    function automatic logic [63:0] sector(logic [63:0] m1, logic [63:0] m2, logic [63:0] t);
        if (t < ONE)
            return m1 + fmul(m2 - m1, t);
        if (t < 3 * ONE)
            return m2;
        if (t < 4 * ONE)
            return m1 + fmul(m2 - m1, 4 * ONE - t);
        return m1;
    endfunction

    function automatic logic [63:0] hue_offset(logic [63:0] start, logic [63:0] pos,
                                               logic [63:0] neg, logic [63:0] delta);
        if (pos >= neg)
            return (start + fdiv(pos - neg, delta)) % (6 * ONE);
        return (start + 6 * ONE - fdiv(neg - pos, delta)) % (6 * ONE);
    endfunction

    function automatic logic [63:0] max3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [63:0] m;
        m = a > b ? a : b;
        return m > c ? m : c;
    endfunction

    function automatic logic [63:0] min3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [63:0] m;
        m = a < b ? a : b;
        return m < c ? m : c;
    endfunction

    function automatic blended_t blend_pixel(pixel_t p);
        logic [63:0] comp, newa, ratio, mx, mn, delta, sum, s, h6, l, m1, m2, inv;
        logic [63:0] cr, cg, cb, orr, og, ob;
        logic [63:0] br, bg, bb, ba, lr, lg, lb, la, mv, op;
        blended_t    res;
        br = 64'(p.br);
        bg = 64'(p.bg);
        bb = 64'(p.bb);
        ba = 64'(p.ba);
        lr = 64'(p.lr);
        lg = 64'(p.lg);
        lb = 64'(p.lb);
        la = 64'(p.la);
        mv = 64'(p.mv);
        op = 64'(opacity_q);
        comp = fmul(ba < la ? ba : la, op);
        if (mask_en_q)
            comp = fmul(comp, mv);
        newa = ba + fmul(ONE - ba, comp);
        if (newa > ONE)
            newa = ONE;
        orr = br;
        og  = bg;
        ob  = bb;
        if (comp != 0 && newa != 0)
        begin
            ratio = fdiv(comp, newa);
            if (ratio > ONE)
                ratio = ONE;
            mx = max3(lr, lg, lb);
            mn = min3(lr, lg, lb);
            delta = mx - mn;
            sum = mx + mn;
            s = 0;
            h6 = 0;
            if (delta != 0)
            begin
                s = fdiv(delta, sum <= ONE ? sum : 2 * ONE - sum);
                if (s > ONE)
                    s = ONE;
                if (lr == mx)
                    h6 = hue_offset(64'd0, lg, lb, delta);
                else if (lg == mx)
                    h6 = hue_offset(2 * ONE, lb, lr, delta);
                else
                    h6 = hue_offset(4 * ONE, lr, lg, delta);
            end
            l = (max3(br, bg, bb) + min3(br, bg, bb) + 1) >> 1;
            if (2 * l <= ONE)
                m2 = l + fmul(l, s);
            else
                m2 = l + s - fmul(l, s);
            if (m2 > ONE)
                m2 = ONE;
            m1 = 2 * l > m2 ? 2 * l - m2 : 0;
            if (m1 > m2)
                m1 = m2;
            cr = sector(m1, m2, (h6 + 2 * ONE) % (6 * ONE));
            cg = sector(m1, m2, h6 % (6 * ONE));
            cb = sector(m1, m2, (h6 + 4 * ONE) % (6 * ONE));
            inv = ONE - ratio;
            orr = (cr * ratio + br * inv + ONE / 2) / ONE;
            og  = (cg * ratio + bg * inv + ONE / 2) / ONE;
            ob  = (cb * ratio + bb * inv + ONE / 2) / ONE;
        end
        res.r = orr[W-1:0];
        res.g = og[W-1:0];
        res.b = ob[W-1:0];
        res.a = p.ba;
        res.last = p.last;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // value biased toward the ends of the range
    function automatic logic [W-1:0] pick16();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return W'($urandom_range(0, 15));
            3: return W'(65535 - $urandom_range(0, 15));
            default: return W'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.br = pick16();
        p.bg = pick16();
        p.bb = pick16();
        p.ba = pick16();
        p.lr = pick16();
        p.lg = pick16();
        p.lb = pick16();
        p.la = pick16();
        p.mv = pick16();
        p.last = 1'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            p.lg = p.lr;
            p.lb = p.lr;
        end
        // keep most alphas well away from zero so the blend path gets used
        if ($urandom_range(0, 3) != 0)
        begin
            p.ba = p.ba | 16'h8000;
            p.la = p.la | 16'h4000;
        end
        return p;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [W-1:0] data);
        logic got;
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.reg_data  <= data;
        do
        begin
            @(negedge clk);
            got = cfg.ready;
            @(posedge clk);
        end while (!got);
        cfg.valid <= 1'b0;
        if (idx == REG_OPACITY)
            opacity_q = data;
        else if (idx == REG_MASK_ENABLE)
            mask_en_q = data[0];
        @(posedge clk);
    endtask

    task automatic send_pixel(pixel_t p, logic typed, blended_t want);
        logic got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.base_red    <= p.br;
        pix_in.base_green  <= p.bg;
        pix_in.base_blue   <= p.bb;
        pix_in.base_alpha  <= p.ba;
        pix_in.layer_red   <= p.lr;
        pix_in.layer_green <= p.lg;
        pix_in.layer_blue  <= p.lb;
        pix_in.layer_alpha <= p.la;
        pix_in.mask_value  <= p.mv;
        pix_in.last_pixel  <= p.last;
        do
        begin
            @(negedge clk);
            got = pix_in.ready;
            @(posedge clk);
        end while (!got);
        pending_px.push_back(typed ? want : blend_pixel(p));
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // receiver: random backpressure plus requested long holds
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pix_out.ready <= 1'b0;
        end
        else
            pix_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(negedge clk)
    begin
        blended_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (pending_px.size() == 0)
            begin
                $display("unexpected output beat at %0t", $realtime);
                err_count++;
            end
            else
            begin
                want = pending_px.pop_front();
                if (pix_out.out_red !== want.r)
                    report_mismatch("red", pix_out.out_red, want.r);
                if (pix_out.out_green !== want.g)
                    report_mismatch("green", pix_out.out_green, want.g);
                if (pix_out.out_blue !== want.b)
                    report_mismatch("blue", pix_out.out_blue, want.b);
                if (pix_out.out_alpha !== want.a)
                    report_mismatch("alpha", pix_out.out_alpha, want.a);
                if (pix_out.out_last !== want.last)
                    report_mismatch("last", W'(pix_out.out_last), W'(want.last));
            end
        end
    end

    initial
    begin
        #4000000;
        $display("hsl_color_blend_composite_test: done, errors");
        $finish;
    end

    initial
    begin
        row_t     rows[$];
        row_t     r;
        pixel_t   p;
        logic [W-1:0] opac_set[5];
        logic     mask_set[5];
        int       n;

        hold_asked = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        opacity_q = W'(65535);
        mask_en_q = 1'b0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.reg_index = '0;
        cfg.reg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.base_red = '0;
        pix_in.base_green = '0;
        pix_in.base_blue = '0;
        pix_in.base_alpha = '0;
        pix_in.layer_red = '0;
        pix_in.layer_green = '0;
        pix_in.layer_blue = '0;
        pix_in.layer_alpha = '0;
        pix_in.mask_value = '0;
        pix_in.last_pixel = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all zero: transparent, passes through
        r = '0;
        r.typed = 1'b1;
        rows.push_back(r);
        // layer alpha zero: base color passes
        r.px = '{16'hffff, 16'h1234, 16'h0000, 16'hffff, 16'hffff, 16'hffff,
                 16'hffff, 16'h0000, 16'hffff, 1'b1};
        r.res = '{16'hffff, 16'h1234, 16'h0000, 16'hffff, 1'b1};
        rows.push_back(r);
        // base alpha zero
        r.px = '{16'h8000, 16'h4000, 16'h2000, 16'h0000, 16'hffff, 16'h0000,
                 16'h0000, 16'hffff, 16'h0000, 1'b0};
        r.res = '{16'h8000, 16'h4000, 16'h2000, 16'h0000, 1'b0};
        rows.push_back(r);
        // full alpha, gray layer over white base: gray at full lightness
        r.px = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h5555, 16'h5555,
                 16'h5555, 16'hffff, 16'h0000, 1'b1};
        r.res = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1};
        rows.push_back(r);
        // full alpha, gray layer over black base
        r.px = '{16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff,
                 16'hffff, 16'hffff, 16'hffff, 1'b0};
        r.res = '{16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0};
        rows.push_back(r);
        r.typed = 1'b0;
        r.res = '0;
        // each hue sector as the max channel, with both signs of the offset
        r.px = '{16'h8000, 16'h4000, 16'h2000, 16'hffff, 16'hffff, 16'h8000,
                 16'h0000, 16'hffff, 16'h0000, 1'b0};
        rows.push_back(r);
        r.px = '{16'h8000, 16'h4000, 16'h2000, 16'hffff, 16'hffff, 16'h0000,
                 16'h8000, 16'hffff, 16'h0000, 1'b0};
        rows.push_back(r);
        r.px = '{16'h3000, 16'h9000, 16'h6000, 16'hffff, 16'h1000, 16'hf000,
                 16'h9000, 16'hffff, 16'h0000, 1'b1};
        rows.push_back(r);
        r.px = '{16'h3000, 16'h9000, 16'h6000, 16'hffff, 16'h9000, 16'hf000,
                 16'h1000, 16'hffff, 16'h0000, 1'b0};
        rows.push_back(r);
        r.px = '{16'hc000, 16'hd000, 16'he000, 16'hffff, 16'h2000, 16'h1000,
                 16'hffff, 16'hffff, 16'h0000, 1'b0};
        rows.push_back(r);
        r.px = '{16'hc000, 16'hd000, 16'he000, 16'hffff, 16'h1000, 16'h2000,
                 16'hffff, 16'hffff, 16'h0000, 1'b1};
        rows.push_back(r);
        // partial alphas, ratio below one
        r.px = '{16'h4000, 16'hc000, 16'h8000, 16'h4000, 16'hffff, 16'h0000,
                 16'hffff, 16'h8000, 16'h1234, 1'b0};
        rows.push_back(r);
        r.px = '{16'h0001, 16'hfffe, 16'h7fff, 16'h0001, 16'h0000, 16'hffff,
                 16'h0001, 16'h0001, 16'hffff, 1'b1};
        rows.push_back(r);
        r.px = '{16'hffff, 16'h0000, 16'hffff, 16'hfffe, 16'hffff, 16'hffff,
                 16'h0000, 16'hffff, 16'h0000, 1'b0};
        rows.push_back(r);

        send_idle_pct = 8;
        recv_idle_pct = 69;
        foreach (rows[i])
            send_pixel(rows[i].px, rows[i].typed, rows[i].res);
        drain();

        opac_set = '{W'(0), W'(32768), W'(65535), W'(1), W'(65535)};
        mask_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        write_reg(REG_UNUSED, W'($urandom));
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 3)
                opac_set[ph] = W'($urandom);
            write_reg(REG_OPACITY, opac_set[ph]);
            write_reg(REG_MASK_ENABLE, W'(mask_set[ph]));
            send_idle_pct = ph < 2 ? 8 : (ph < 4 ? 69 : 0);
            recv_idle_pct = ph < 2 ? 69 : (ph < 4 ? 8 : 0);
            n = 260;
            for (int k = 0; k < n; k++)
            begin
                if (ph == 2 && k == 60)
                    hold_asked++;
                if (ph == 4 && k == 130)
                begin
                    // sender pauses until the pipeline has emptied
                    pix_in.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_px.size() != 0)
                        @(posedge clk);
                end
                p = random_pixel();
                send_pixel(p, 1'b0, '0);
            end
            drain();
        end

        if (err_count == 0)
            $display("hsl_color_blend_composite_test: done, clean");
        else
            $display("hsl_color_blend_composite_test: done, errors");
        $finish;
    end

endmodule

// ===== hsl_color_blend_composite.f =====
hdl/hslc_pkg.sv
hdl/hslc_if.sv
hdl/hslc_div.sv
hdl/hsl_color_blend_composite.sv
bench/hsl_color_blend_composite_test.sv
